// ===== design/assert_macros.svh =====
// Assertion macros shared by the tokenizer RTL.
// Simulation gets the checks; synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SST_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("assertion failed");
`define SST_NEVER(lbl, clk, rstn, cond) `SST_ASSERT(lbl, clk, rstn, !(cond))
`else
`define SST_ASSERT(lbl, clk, rstn, prop)
`define SST_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ===== design/sst_pkg.sv =====
// Shared types, codes, character classes and word tables of the tokenizer.
// No dependencies; used by every module of the block.
package sst_pkg;

    localparam int MAX_RES        = 3;
    localparam int OUTQ_DEPTH     = 8;   // power of two
    localparam int WORD_CHARS_DEF = 8;
    localparam int POS_BITS_DEF   = 16;
    localparam logic [15:0] FIRST_LINE_RST = 16'd1;
    localparam logic [15:0] FIRST_COL_RST  = 16'd0;

    typedef enum logic [0:0] {
        CFG_FIRST_LINE = 1'b0,
        CFG_FIRST_COL  = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        TK_IDENT, TK_KEYWORD, TK_NUMBER, TK_STRING, TK_OPER,
        TK_DIRECTIVE, TK_NEWLINE, TK_UNKNOWN, TK_END
    } t_kind;

    localparam logic [5:0] OP_DIV_EQ   = 6'd13;
    localparam logic [5:0] OP_ELLIPSIS = 6'd14;
    localparam logic [5:0] OP_RANGE    = 6'd15;
    localparam logic [5:0] OP_DOT      = 6'd26;
    localparam logic [5:0] OP_DIV      = 6'd32;
    localparam logic [5:0] DIR_WARNING = 6'd10;
    localparam logic [5:0] CODE_NONE   = 6'd0;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_BSL   = 8'h5C;

    localparam logic [62:0] VAL_MAX = '1;

    typedef struct packed {
        t_kind       kind;
        logic [5:0]  code;
        logic [15:0] sline;
        logic [15:0] scol;
        logic [15:0] len;
        logic [62:0] ival;
        logic        isf;
        logic        ovf;
        logic [15:0] depth;
        logic        last;
    } t_tok;

    localparam int N_KW  = 31;
    localparam int N_DIR = 13;

    // text is right aligned: char i of a word of length L sits at byte L-1-i
    localparam logic [63:0] KW_TEXT [N_KW] = '{
        64'("var"), 64'("proc"), 64'("verb"), 64'("if"), 64'("else"), 64'("for"),
        64'("while"), 64'("do"), 64'("switch"), 64'("case"), 64'("default"),
        64'("return"), 64'("break"), 64'("continue"), 64'("goto"), 64'("del"),
        64'("new"), 64'("in"), 64'("to"), 64'("step"), 64'("as"), 64'("null"),
        64'("set"), 64'("tmp"), 64'("const"), 64'("static"), 64'("global"),
        64'("spawn"), 64'("try"), 64'("catch"), 64'("throw")};
    localparam int KW_LEN [N_KW] = '{
        3, 4, 4, 2, 4, 3, 5, 2, 6, 4, 7, 6, 5, 8, 4, 3, 3, 2, 2, 4, 2, 4,
        3, 3, 5, 6, 6, 5, 3, 5, 5};

    // the last name is an alias of warning
    localparam logic [63:0] DIR_TEXT [N_DIR] = '{
        64'("include"), 64'("define"), 64'("undef"), 64'("if"), 64'("ifdef"),
        64'("ifndef"), 64'("elif"), 64'("else"), 64'("endif"), 64'("error"),
        64'("warning"), 64'("pragma"), 64'("warn")};
    localparam int DIR_LEN [N_DIR] = '{7, 6, 5, 2, 5, 6, 4, 4, 5, 5, 7, 6, 4};

    function automatic logic is_digit(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

    function automatic logic is_idch(logic [7:0] c);
        return is_alpha(c) || is_digit(c);
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_val(logic [7:0] c);
        logic [7:0] t;
        t = 8'h00;
        if (is_digit(c)) begin
            t = c - 8'h30;
            return {1'b1, t[3:0]};
        end
        if ((c >= "a") && (c <= "f")) begin
            t = c - 8'h57;
            return {1'b1, t[3:0]};
        end
        if ((c >= "A") && (c <= "F")) begin
            t = c - 8'h37;
            return {1'b1, t[3:0]};
        end
        return 5'd0;
    endfunction

    function automatic logic is_op_lead(logic [7:0] c);
        return (c == "=") || (c == "!") || (c == "<") || (c == ">") || (c == "&") ||
               (c == "|") || (c == "+") || (c == "-") || (c == "*") || (c == ":");
    endfunction

    // {valid, code} for a two character operator
    function automatic logic [6:0] two_code(logic [7:0] h, logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        case (h)
            "=": if (c == "=") r = {1'b1, 6'd0};
            "!": if (c == "=") r = {1'b1, 6'd1};
            "<": begin
                if (c == "=") r = {1'b1, 6'd2};
                else if (c == "<") r = {1'b1, 6'd6};
            end
            ">": begin
                if (c == "=") r = {1'b1, 6'd3};
                else if (c == ">") r = {1'b1, 6'd7};
            end
            "&": if (c == "&") r = {1'b1, 6'd4};
            "|": if (c == "|") r = {1'b1, 6'd5};
            "+": begin
                if (c == "+") r = {1'b1, 6'd8};
                else if (c == "=") r = {1'b1, 6'd10};
            end
            "-": begin
                if (c == "-") r = {1'b1, 6'd9};
                else if (c == "=") r = {1'b1, 6'd11};
            end
            "*": if (c == "=") r = {1'b1, 6'd12};
            ":": if (c == ":") r = {1'b1, 6'd16};
            default: r = 7'd0;
        endcase
        return r;
    endfunction

    // {valid, code} for a single character operator
    function automatic logic [6:0] single_op(logic [7:0] c);
        logic [6:0] r;
        case (c)
            "(":     r = {1'b1, 6'd17};
            ")":     r = {1'b1, 6'd18};
            "[":     r = {1'b1, 6'd19};
            "]":     r = {1'b1, 6'd20};
            "{":     r = {1'b1, 6'd21};
            "}":     r = {1'b1, 6'd22};
            ";":     r = {1'b1, 6'd23};
            ",":     r = {1'b1, 6'd24};
            ":":     r = {1'b1, 6'd25};
            ".":     r = {1'b1, 6'd26};
            "?":     r = {1'b1, 6'd27};
            "=":     r = {1'b1, 6'd28};
            "+":     r = {1'b1, 6'd29};
            "-":     r = {1'b1, 6'd30};
            "*":     r = {1'b1, 6'd31};
            "/":     r = {1'b1, 6'd32};
            "%":     r = {1'b1, 6'd33};
            "<":     r = {1'b1, 6'd34};
            ">":     r = {1'b1, 6'd35};
            "!":     r = {1'b1, 6'd36};
            "&":     r = {1'b1, 6'd37};
            "|":     r = {1'b1, 6'd38};
            "^":     r = {1'b1, 6'd39};
            "~":     r = {1'b1, 6'd40};
            default: r = 7'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/sst_lexer.sv =====
// Lexer state and per-character step logic: up to three token records per item.
// Depends on sst_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sst_lexer #(
    parameter int WORD_CHARS = sst_pkg::WORD_CHARS_DEF,
    parameter int POS_BITS   = sst_pkg::POS_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_vld,
    input  logic [7:0]                           i_char,
    input  logic                                 i_eos,
    input  logic [15:0]                          i_first_line,
    input  logic [15:0]                          i_first_col,
    output sst_pkg::t_tok [sst_pkg::MAX_RES-1:0] o_res,
    output logic [1:0]                           o_res_cnt
);
    import sst_pkg::*;

    localparam int WL_W  = $clog2(WORD_CHARS + 2);
    localparam int IDX_W = $clog2(WORD_CHARS);
    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    typedef enum logic [4:0] {
        PH_IDLE, PH_WS, PH_SLASH, PH_LINE, PH_BLK, PH_BLK_STAR, PH_POSTBLK,
        PH_OP, PH_DOT, PH_DOTDOT, PH_IDENT, PH_NUM_ZERO, PH_NUM_INT, PH_NUM_DOT,
        PH_NUM_FRAC, PH_NUM_EXP, PH_NUM_EXPD, PH_HEX, PH_STR, PH_STR_ESC,
        PH_DIR_WS, PH_DIR_NAME
    } t_phase;

    typedef struct packed {
        t_phase              phase;
        logic [7:0]          held;
        logic [WL_W-1:0]     wlen;
        logic [15:0]         run;
        logic [POS_BITS-1:0] sline;
        logic [POS_BITS-1:0] scol;
        logic [POS_BITS-1:0] line;
        logic [POS_BITS-1:0] col;
        logic [62:0]         acc;
        logic                sq;
        logic                flt;
        logic                ovf;
        logic [15:0]         depth;
    } t_lex;

    function automatic logic [POS_BITS-1:0] clamp_pos(logic [15:0] v);
        logic [32:0] w;
        w = 33'(v);
        if (w > 33'(POS_MAX)) return POS_MAX;
        return w[POS_BITS-1:0];
    endfunction

    function automatic t_lex reset_val();
        t_lex r;
        r       = '0;
        r.phase = PH_IDLE;
        r.line  = clamp_pos(FIRST_LINE_RST);
        r.col   = clamp_pos(FIRST_COL_RST);
        return r;
    endfunction

    function automatic logic [15:0] to16(logic [POS_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[15:0];
    endfunction

    function automatic logic [15:0] grow(logic [15:0] r);
        return (r == 16'hFFFF) ? r : r + 16'd1;
    endfunction

    function automatic t_tok mk(t_lex s, t_kind k, logic [5:0] code, logic isnum);
        t_tok t;
        t.kind  = k;
        t.code  = code;
        t.sline = to16(s.sline);
        t.scol  = to16(s.scol);
        t.len   = s.run;
        t.ival  = (isnum && !s.flt) ? s.acc : 63'd0;
        t.isf   = isnum && s.flt;
        t.ovf   = isnum && !s.flt && s.ovf;
        t.depth = s.depth;
        t.last  = 1'b0;
        return t;
    endfunction

    // value*base + digit; overflow when the result leaves 63 bits
    function automatic t_lex acc_digit(t_lex s, logic hex, logic [3:0] d);
        t_lex       r;
        logic [66:0] a;
        logic [66:0] t;
        r = s;
        a = 67'(s.acc);
        t = hex ? ((a << 4) + 67'(d)) : ((a << 3) + (a << 1) + 67'(d));
        if (!s.ovf) begin
            if (t > 67'(VAL_MAX)) begin
                r.acc = VAL_MAX;
                r.ovf = 1'b1;
            end else begin
                r.acc = t[62:0];
            end
        end
        return r;
    endfunction

    function automatic t_lex word_put(t_lex s);
        t_lex r;
        r = s;
        if (s.wlen <= WL_W'(WORD_CHARS)) r.wlen = s.wlen + 1'b1;
        return r;
    endfunction

    t_lex       r_st;
    t_lex       n_st;
    logic [7:0] r_word [WORD_CHARS];

    logic              word_we;
    logic [IDX_W-1:0]  word_idx;
    logic [7:0]        word_dat;
    logic              kw_hit;
    logic [5:0]        kw_code;
    logic              dir_hit;
    logic [5:0]        dir_code;
    t_tok [MAX_RES-1:0] res;
    logic [1:0]        ne;

    // keyword and directive match against the registered word
    always_comb begin
        logic ok;
        kw_hit  = 1'b0;
        kw_code = CODE_NONE;
        for (int k = N_KW - 1; k >= 0; k--) begin
            ok = (r_st.wlen == WL_W'(KW_LEN[k]));
            for (int i = 0; i < WORD_CHARS; i++) begin
                if ((i < KW_LEN[k]) && (i < 8) &&
                    (r_word[i] != KW_TEXT[k][8*(KW_LEN[k]-1-i) +: 8])) ok = 1'b0;
            end
            if (ok) begin
                kw_hit  = 1'b1;
                kw_code = 6'(k);
            end
        end
        dir_hit  = 1'b0;
        dir_code = CODE_NONE;
        for (int k = N_DIR - 1; k >= 0; k--) begin
            ok = (r_st.wlen == WL_W'(DIR_LEN[k]));
            for (int i = 0; i < WORD_CHARS; i++) begin
                if ((i < DIR_LEN[k]) && (i < 8) &&
                    (r_word[i] != DIR_TEXT[k][8*(DIR_LEN[k]-1-i) +: 8])) ok = 1'b0;
            end
            if (ok) begin
                dir_hit  = 1'b1;
                dir_code = (k == N_DIR - 1) ? DIR_WARNING : 6'(k);
            end
        end
    end

    always_comb begin
        t_lex       s;
        logic [7:0] c;
        logic       re;
        logic       do_dot;
        logic       do_idle;
        logic [1:0] nl;
        logic [6:0] op;
        logic [4:0] hv;
        logic [7:0] lc;
        s        = r_st;
        c        = i_char;
        re       = 1'b0;
        do_dot   = 1'b0;
        do_idle  = 1'b0;
        nl       = 2'd0;
        op       = 7'd0;
        hv       = hex_val(c);
        lc       = ((c >= "A") && (c <= "Z")) ? c + 8'd32 : c;
        ne       = 2'd0;
        res      = '0;
        word_we  = 1'b0;
        word_idx = r_st.wlen[IDX_W-1:0];
        word_dat = c;

        if (i_eos) begin
            case (s.phase)
                PH_SLASH: begin
                    res[ne] = mk(s, TK_OPER, OP_DIV, 1'b0); ne = ne + 2'd1;
                end
                PH_OP: begin
                    op = single_op(s.held);
                    res[ne] = op[6] ? mk(s, TK_OPER, op[5:0], 1'b0)
                                    : mk(s, TK_UNKNOWN, CODE_NONE, 1'b0);
                    ne = ne + 2'd1;
                end
                PH_DOT: begin
                    res[ne] = mk(s, TK_OPER, OP_DOT, 1'b0); ne = ne + 2'd1;
                end
                PH_DOTDOT: begin
                    res[ne] = mk(s, TK_OPER, OP_RANGE, 1'b0); ne = ne + 2'd1;
                end
                PH_IDENT: begin
                    res[ne] = kw_hit ? mk(s, TK_KEYWORD, kw_code, 1'b0)
                                     : mk(s, TK_IDENT, CODE_NONE, 1'b0);
                    ne = ne + 2'd1;
                end
                PH_NUM_ZERO, PH_NUM_INT, PH_NUM_FRAC, PH_NUM_EXP, PH_NUM_EXPD,
                PH_HEX: begin
                    res[ne] = mk(s, TK_NUMBER, CODE_NONE, 1'b1); ne = ne + 2'd1;
                end
                PH_NUM_DOT: begin
                    res[ne] = mk(s, TK_NUMBER, CODE_NONE, 1'b1); ne = ne + 2'd1;
                    s.sline = s.line;
                    s.scol  = (s.col != '0) ? s.col - 1'b1 : '0;
                    s.run   = 16'd1;
                    s.sq    = 1'b0;
                    s.flt   = 1'b0;
                    s.ovf   = 1'b0;
                    s.acc   = '0;
                    res[ne] = mk(s, TK_OPER, OP_DOT, 1'b0); ne = ne + 2'd1;
                end
                PH_STR, PH_STR_ESC: begin
                    res[ne] = mk(s, TK_STRING, CODE_NONE, 1'b0); ne = ne + 2'd1;
                end
                PH_DIR_NAME: begin
                    if (dir_hit) begin
                        res[ne] = mk(s, TK_DIRECTIVE, dir_code, 1'b0); ne = ne + 2'd1;
                    end
                end
                default: ;
            endcase
            s.sline = s.line;
            s.scol  = s.col;
            s.run   = 16'd0;
            s.sq    = 1'b0;
            s.flt   = 1'b0;
            s.ovf   = 1'b0;
            res[ne] = mk(s, TK_END, CODE_NONE, 1'b0); ne = ne + 2'd1;
            s       = '0;
            s.phase = PH_IDLE;
            s.line  = clamp_pos(i_first_line);
            s.col   = clamp_pos(i_first_col);
        end else begin
            // first pass: the phase left by the previous character
            case (s.phase)
                PH_WS: begin
                    if (!((c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR))) begin
                        s.phase = PH_IDLE;
                        re = 1'b1;
                    end
                end
                PH_POSTBLK: begin
                    if (!((c == CH_SPACE) || (c == CH_TAB))) begin
                        s.phase = PH_IDLE;
                        re = 1'b1;
                    end
                end
                PH_SLASH: begin
                    if (c == "/") s.phase = PH_LINE;
                    else if (c == "*") s.phase = PH_BLK;
                    else if (c == "=") begin
                        s.run = grow(s.run);
                        res[ne] = mk(s, TK_OPER, OP_DIV_EQ, 1'b0); ne = ne + 2'd1;
                        s.phase = PH_IDLE;
                    end else begin
                        res[ne] = mk(s, TK_OPER, OP_DIV, 1'b0); ne = ne + 2'd1;
                        s.phase = PH_IDLE;
                        re = 1'b1;
                    end
                end
                PH_LINE: begin
                    if (c == CH_LF) begin
                        nl = 2'd1;
                        s.phase = PH_IDLE;
                    end
                end
                PH_BLK: begin
                    if (c == "*") s.phase = PH_BLK_STAR;
                    else if (c == CH_LF) nl = 2'd2;
                end
                PH_BLK_STAR: begin
                    if (c == "/") s.phase = PH_POSTBLK;
                    else if (c != "*") begin
                        if (c == CH_LF) nl = 2'd2;
                        s.phase = PH_BLK;
                    end
                end
                PH_OP: begin
                    op = two_code(s.held, c);
                    s.phase = PH_IDLE;
                    if (op[6]) begin
                        s.run = grow(s.run);
                        res[ne] = mk(s, TK_OPER, op[5:0], 1'b0); ne = ne + 2'd1;
                    end else begin
                        op = single_op(s.held);
                        res[ne] = op[6] ? mk(s, TK_OPER, op[5:0], 1'b0)
                                        : mk(s, TK_UNKNOWN, CODE_NONE, 1'b0);
                        ne = ne + 2'd1;
                        re = 1'b1;
                    end
                end
                PH_DOT: do_dot = 1'b1;
                PH_DOTDOT: begin
                    s.phase = PH_IDLE;
                    if (c == ".") begin
                        s.run = grow(s.run);
                        res[ne] = mk(s, TK_OPER, OP_ELLIPSIS, 1'b0); ne = ne + 2'd1;
                    end else begin
                        res[ne] = mk(s, TK_OPER, OP_RANGE, 1'b0); ne = ne + 2'd1;
                        re = 1'b1;
                    end
                end
                PH_IDENT: begin
                    if (is_idch(c)) begin
                        word_we = (r_st.wlen < WL_W'(WORD_CHARS));
                        s = word_put(s);
                        s.run = grow(s.run);
                    end else begin
                        res[ne] = kw_hit ? mk(s, TK_KEYWORD, kw_code, 1'b0)
                                         : mk(s, TK_IDENT, CODE_NONE, 1'b0);
                        ne = ne + 2'd1;
                        s.phase = PH_IDLE;
                        re = 1'b1;
                    end
                end
                PH_NUM_ZERO, PH_NUM_INT: begin
                    if ((s.phase == PH_NUM_ZERO) && ((c == "x") || (c == "X"))) begin
                        s.run = grow(s.run);
                        s.phase = PH_HEX;
                    end else begin
                        s.phase = PH_NUM_INT;
                        if (is_digit(c)) begin
                            s = acc_digit(s, 1'b0, hv[3:0]);
                            s.run = grow(s.run);
                        end else if (c == ".") begin
                            s.phase = PH_NUM_DOT;
                        end else if ((c == "e") || (c == "E")) begin
                            s.flt = 1'b1;
                            s.run = grow(s.run);
                            s.phase = PH_NUM_EXP;
                        end else begin
                            res[ne] = mk(s, TK_NUMBER, CODE_NONE, 1'b1); ne = ne + 2'd1;
                            s.phase = PH_IDLE;
                            re = 1'b1;
                        end
                    end
                end
                PH_NUM_DOT: begin
                    if (is_digit(c)) begin
                        s.run = grow(grow(s.run));
                        s.flt = 1'b1;
                        s.phase = PH_NUM_FRAC;
                    end else begin
                        res[ne] = mk(s, TK_NUMBER, CODE_NONE, 1'b1); ne = ne + 2'd1;
                        // the dot becomes its own token, one column back
                        s.sline = s.line;
                        s.scol  = (s.col != '0) ? s.col - 1'b1 : '0;
                        s.run   = 16'd1;
                        s.sq    = 1'b0;
                        s.flt   = 1'b0;
                        s.ovf   = 1'b0;
                        s.acc   = '0;
                        s.phase = PH_DOT;
                        do_dot  = 1'b1;
                    end
                end
                PH_NUM_FRAC, PH_NUM_EXP, PH_NUM_EXPD: begin
                    if (is_digit(c) ||
                        ((s.phase == PH_NUM_EXP) && ((c == "+") || (c == "-")))) begin
                        s.run = grow(s.run);
                        if (s.phase == PH_NUM_EXP) s.phase = PH_NUM_EXPD;
                    end else if ((s.phase == PH_NUM_FRAC) && ((c == "e") || (c == "E"))) begin
                        s.run = grow(s.run);
                        s.phase = PH_NUM_EXP;
                    end else begin
                        res[ne] = mk(s, TK_NUMBER, CODE_NONE, 1'b1); ne = ne + 2'd1;
                        s.phase = PH_IDLE;
                        re = 1'b1;
                    end
                end
                PH_HEX: begin
                    if (hv[4]) begin
                        s = acc_digit(s, 1'b1, hv[3:0]);
                        s.run = grow(s.run);
                    end else begin
                        res[ne] = mk(s, TK_NUMBER, CODE_NONE, 1'b1); ne = ne + 2'd1;
                        s.phase = PH_IDLE;
                        re = 1'b1;
                    end
                end
                PH_STR: begin
                    s.run = grow(s.run);
                    if (c == (s.sq ? CH_SQ : CH_DQ)) begin
                        res[ne] = mk(s, TK_STRING, CODE_NONE, 1'b0); ne = ne + 2'd1;
                        s.phase = PH_IDLE;
                    end else if (c == CH_BSL) begin
                        s.phase = PH_STR_ESC;
                    end
                end
                PH_STR_ESC: begin
                    s.run = grow(s.run);
                    s.phase = PH_STR;
                end
                PH_DIR_WS, PH_DIR_NAME: begin
                    if ((s.phase == PH_DIR_WS) && ((c == CH_SPACE) || (c == CH_TAB))) begin
                        s.run = grow(s.run);
                    end else if (is_idch(c)) begin
                        word_we  = (r_st.wlen < WL_W'(WORD_CHARS));
                        word_dat = lc;
                        s = word_put(s);
                        s.run = grow(s.run);
                        s.phase = PH_DIR_NAME;
                    end else begin
                        if ((s.phase == PH_DIR_NAME) && dir_hit) begin
                            res[ne] = mk(s, TK_DIRECTIVE, dir_code, 1'b0); ne = ne + 2'd1;
                        end
                        s.phase = PH_IDLE;
                        re = 1'b1;
                    end
                end
                default: do_idle = 1'b1;
            endcase

            // a lone dot waiting for its follower
            if (do_dot) begin
                if (is_digit(c)) begin
                    s.run = grow(s.run);
                    s.flt = 1'b1;
                    s.phase = PH_NUM_FRAC;
                end else if (c == ".") begin
                    s.run = grow(s.run);
                    s.phase = PH_DOTDOT;
                end else begin
                    res[ne] = mk(s, TK_OPER, OP_DOT, 1'b0); ne = ne + 2'd1;
                    s.phase = PH_IDLE;
                    re = 1'b1;
                end
            end

            // character starts a new token or a whitespace run
            if (do_idle || re) begin
                s.phase = PH_IDLE;
                if ((c == CH_SPACE) || (c == CH_TAB)) begin
                    s.phase = PH_WS;
                end else begin
                    s.sline = s.line;
                    s.scol  = s.col;
                    s.run   = 16'd1;
                    s.sq    = 1'b0;
                    s.flt   = 1'b0;
                    s.ovf   = 1'b0;
                    s.acc   = '0;
                    s.wlen  = '0;
                    if ((c == "(") || (c == "[") || (c == "{")) begin
                        if (s.depth != 16'hFFFF) s.depth = s.depth + 16'd1;
                    end else if ((c == ")") || (c == "]") || (c == "}")) begin
                        if (s.depth != 16'd0) s.depth = s.depth - 16'd1;
                    end
                    if (c == "/") s.phase = PH_SLASH;
                    else if (c == CH_LF) begin
                        res[ne] = mk(s, TK_NEWLINE, CODE_NONE, 1'b0); ne = ne + 2'd1;
                        nl = 2'd1;
                    end else if ((c == CH_DQ) || (c == CH_SQ)) begin
                        s.sq = (c == CH_SQ);
                        s.phase = PH_STR;
                    end else if (is_digit(c)) begin
                        s.acc = 63'(hv[3:0]);
                        s.phase = (c == "0") ? PH_NUM_ZERO : PH_NUM_INT;
                    end else if (c == ".") s.phase = PH_DOT;
                    else if (c == "#") s.phase = PH_DIR_WS;
                    else if (is_alpha(c)) begin
                        word_we  = 1'b1;
                        word_idx = '0;
                        word_dat = c;
                        s.wlen   = WL_W'(1);
                        s.phase  = PH_IDENT;
                    end else if (is_op_lead(c)) begin
                        s.held  = c;
                        s.phase = PH_OP;
                    end else begin
                        op = single_op(c);
                        res[ne] = op[6] ? mk(s, TK_OPER, op[5:0], 1'b0)
                                        : mk(s, TK_UNKNOWN, CODE_NONE, 1'b0);
                        ne = ne + 2'd1;
                    end
                end
            end

            if (nl != 2'd0) begin
                s.line = (s.line != POS_MAX) ? s.line + 1'b1 : POS_MAX;
                s.col  = (nl == 2'd2) ? POS_BITS'(1) : '0;
            end else if (s.col != POS_MAX) begin
                s.col = s.col + 1'b1;
            end
        end

        for (int j = 0; j < MAX_RES; j++) begin
            if ((ne != 2'd0) && (j == int'(ne) - 1)) res[j].last = 1'b1;
        end
        n_st = s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= reset_val();
        end else if (i_vld) begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld && !i_eos && word_we) r_word[word_idx] <= word_dat;
    end

    assign o_res     = res;
    assign o_res_cnt = i_vld ? ne : 2'd0;

    `SST_ASSERT(a_eos_clears, i_clk, i_rst_n, i_vld && i_eos |=> (r_st.phase == PH_IDLE) && (r_st.depth == 16'd0))
    `SST_ASSERT(a_hold_state, i_clk, i_rst_n, !i_vld |=> $stable(r_st))
    `SST_NEVER(a_eos_emits, i_clk, i_rst_n, i_vld && i_eos && (ne == 2'd0))

endmodule

// ===== design/sst_outq.sv =====
// Result queue: takes up to three token records a cycle, hands out one when popped.
// Depends on sst_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sst_outq #(
    parameter int DEPTH = sst_pkg::OUTQ_DEPTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  sst_pkg::t_tok [sst_pkg::MAX_RES-1:0] i_res,
    input  logic [1:0]                           i_cnt,
    input  logic                                 i_pop,
    output sst_pkg::t_tok                        o_head,
    output logic                                 o_vld,
    output logic [$clog2(DEPTH+1)-1:0]           o_count
);
    import sst_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_tok             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             pop;

    assign pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PTR_W'(i_cnt);
            r_rd    <= r_rd + PTR_W'(pop);
            r_count <= r_count + CNT_W'(i_cnt) - CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < MAX_RES; j++) begin
            if (j < int'(i_cnt)) r_mem[PTR_W'(r_wr + PTR_W'(j))] <= i_res[j];
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_vld   = (r_count != '0);
    assign o_count = r_count;

    `SST_NEVER(a_no_overrun, i_clk, i_rst_n, (CNT_W+2)'(r_count) + (CNT_W+2)'(i_cnt) > (CNT_W+2)'(DEPTH))
    `SST_NEVER(a_count_max, i_clk, i_rst_n, r_count > CNT_W'(DEPTH))
    `SST_ASSERT(a_empty_stays, i_clk, i_rst_n, (r_count == '0) && (i_cnt == 2'd0) |=> (r_count == '0))

endmodule

// ===== design/script_source_tokenizer_core.sv =====
// Top level of the source tokenizer: input register, config registers,
// lexer step and result queue. Depends on sst_pkg, sst_lexer, sst_outq.
//
//   channel   | ports              | moves
//   ----------+--------------------+------------------------------------------
//   slave in  | i_s_axis_*         | one source byte or end mark per transaction
//   master out| o_m_axis_*         | one token record per transaction
//   config    | i_cfg_we/addr/wdata| first_line (0), first_column (1)
//
// An item is registered on acceptance and lexed in the next cycle; its records
// enter the 8-entry result queue at the end of that cycle, and the first one shows
// on the master side once the queue has registered it.
// One item per cycle while tready is high; up to three records per item drain one
// per cycle as taken; tready drops while the queue holds more than two records.
// Reset is synchronous, active low; config writes apply at the next end mark.
`include "assert_macros.svh"
module script_source_tokenizer_core #(
    parameter int WORD_CHARS = sst_pkg::WORD_CHARS_DEF,
    parameter int POS_BITS   = sst_pkg::POS_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // [7:0] char_code
    input  logic         i_s_axis_tuser,   // [0] end_of_source
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [5:0] token_code, [21:6] start_line, [37:22] start_column,
    // [53:38] token_length, [116:54] int_value, [117] is_float,
    // [118] value_overflow, [134:119] bracket_depth, [135] zero
    output logic [135:0] o_m_axis_tdata,
    output logic [3:0]   o_m_axis_tuser,   // [3:0] token_kind
    output logic         o_m_axis_tlast,
    input  logic         i_cfg_we,
    input  logic [0:0]   i_cfg_addr,
    input  logic [15:0]  i_cfg_wdata
);
    import sst_pkg::*;

    localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

    logic               r_in_vld;
    logic [7:0]         r_in_char;
    logic               r_in_eos;
    logic [15:0]        r_first_line;
    logic [15:0]        r_first_col;
    t_tok [MAX_RES-1:0] res;
    logic [1:0]         res_cnt;
    t_tok               head;
    logic [CNT_W-1:0]   q_count;
    logic               accept;

    // room for the registered item and a new one, three records each
    assign o_s_axis_tready = (q_count <= CNT_W'(OUTQ_DEPTH - 2 * MAX_RES));
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_first_line <= FIRST_LINE_RST;
            r_first_col  <= FIRST_COL_RST;
        end else begin
            r_in_vld <= accept;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_FIRST_LINE: r_first_line <= i_cfg_wdata;
                    CFG_FIRST_COL:  r_first_col  <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_char <= i_s_axis_tdata;
            r_in_eos  <= i_s_axis_tuser;
        end
    end

    sst_lexer #(
        .WORD_CHARS (WORD_CHARS),
        .POS_BITS   (POS_BITS)
    ) u_lexer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vld        (r_in_vld),
        .i_char       (r_in_char),
        .i_eos        (r_in_eos),
        .i_first_line (r_first_line),
        .i_first_col  (r_first_col),
        .o_res        (res),
        .o_res_cnt    (res_cnt)
    );

    sst_outq #(
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .i_cnt   (res_cnt),
        .i_pop   (i_m_axis_tready),
        .o_head  (head),
        .o_vld   (o_m_axis_tvalid),
        .o_count (q_count)
    );

    assign o_m_axis_tdata = {1'b0, head.depth, head.ovf, head.isf, head.ival,
                             head.len, head.scol, head.sline, head.code};
    assign o_m_axis_tuser = head.kind;
    assign o_m_axis_tlast = head.last;

endmodule

// ===== tb/tb_script_source_tokenizer_core.sv =====
// Self-checking testbench for script_source_tokenizer_core: streams source bytes
// and end marks, predicts every token record and checks the master side in order.
// Depends on sst_pkg and the tokenizer RTL.
`timescale 1ns / 1ps
module tb_script_source_tokenizer_core;
    import sst_pkg::*;

    localparam int    IDLE_LIMIT = 20000;
    localparam int    HOLD_CYCLES = 300;
    localparam int    DRAIN_CYCLES = 12;
    localparam int    ITEM_TARGET = 310;
    localparam string OP_CHARS = "()[]{};,:.?=+-*/%<>!&|^~";
    localparam string NAME_CHARS = "aZ_q9";
    localparam logic [63:0] ACC_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum int {
        LX_IDLE, LX_WS, LX_SLASH, LX_LINE, LX_BLK, LX_BSTAR, LX_POSTBLK, LX_OP,
        LX_DOT, LX_DOTDOT, LX_IDENT, LX_ZERO, LX_INT, LX_NDOT, LX_FRAC, LX_EXP,
        LX_EXPD, LX_HEX, LX_STR, LX_ESC, LX_DIR_WS, LX_DIR_NAME
    } t_lex_phase;

    localparam int F_SQ = 1, F_FLOAT = 2, F_OVF = 4;

    string kw_names[31] = '{"var", "proc", "verb", "if", "else", "for", "while", "do",
        "switch", "case", "default", "return", "break", "continue", "goto", "del", "new",
        "in", "to", "step", "as", "null", "set", "tmp", "const", "static", "global",
        "spawn", "try", "catch", "throw"};
    string dir_names[13] = '{"include", "define", "undef", "if", "ifdef", "ifndef",
        "elif", "else", "endif", "error", "warning", "pragma", "warn"};
    string op_words[17] = '{"==", "!=", "<=", ">=", "&&", "||", "<<", ">>", "++", "--",
        "+=", "-=", "*=", "/=", "...", "..", "::"};

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [7:0]   i_s_axis_tdata = '0;
    logic         i_s_axis_tuser = 1'b0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [135:0] o_m_axis_tdata;
    logic [3:0]   o_m_axis_tuser;
    logic         o_m_axis_tlast;
    logic         i_cfg_we = 1'b0;
    logic [0:0]   i_cfg_addr = '0;
    logic [15:0]  i_cfg_wdata = '0;

    script_source_tokenizer_core dut (.*);

    always #4 i_clk = ~i_clk;

    // predictor state
    int unsigned cfg_line = 1, cfg_col = 0;
    t_lex_phase  phase;
    logic [7:0]  held, wbuf[8];
    int unsigned wlen, run_len, tok_line, tok_col, line_now, col_now, flags, depth;
    logic [63:0] acc;
    int          nl_mode;
    t_tok        step_tokens[$];
    t_tok        expected_tokens[$];

    int errors = 0;
    int items_sent = 0;
    int burst_left = 0;
    bit hold_req = 1'b0;

    function automatic void reset_lexer();
        phase = LX_IDLE; held = 0; wlen = 0; run_len = 0; tok_line = 0; tok_col = 0;
        line_now = cfg_line; col_now = cfg_col; acc = 0; flags = 0; depth = 0;
        foreach (wbuf[i]) wbuf[i] = 0;
    endfunction

    function automatic void emit_tok(int kind, int code, bit isnum);
        t_tok t;
        bit fl;
        fl = (flags & F_FLOAT) != 0;
        if (step_tokens.size() >= MAX_RES) return;
        t.kind = t_kind'(kind);
        t.code = code[5:0];
        t.sline = tok_line[15:0];
        t.scol = tok_col[15:0];
        t.len = run_len[15:0];
        t.ival = (isnum && !fl) ? acc[62:0] : '0;
        t.isf = isnum && fl;
        t.ovf = isnum && !fl && ((flags & F_OVF) != 0);
        t.depth = depth[15:0];
        t.last = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic void emit_single(logic [7:0] c);
        for (int i = 0; i < OP_CHARS.len(); i++)
            if (OP_CHARS[i] == c) begin
                emit_tok(TK_OPER, 17 + i, 0);
                return;
            end
        emit_tok(TK_UNKNOWN, CODE_NONE, 0);
    endfunction

    function automatic int pair_code(logic [7:0] h, logic [7:0] c);
        case (h)
            "=": return c == "=" ? 0 : -1;
            "!": return c == "=" ? 1 : -1;
            "<": return c == "=" ? 2 : (c == "<" ? 6 : -1);
            ">": return c == "=" ? 3 : (c == ">" ? 7 : -1);
            "&": return c == "&" ? 4 : -1;
            "|": return c == "|" ? 5 : -1;
            "+": return c == "+" ? 8 : (c == "=" ? 10 : -1);
            "-": return c == "-" ? 9 : (c == "=" ? 11 : -1);
            "*": return c == "=" ? 12 : -1;
            ":": return c == ":" ? 16 : -1;
            default: return -1;
        endcase
    endfunction

    function automatic bit digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction
    function automatic bit alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction
    function automatic bit word_char(logic [7:0] c);
        return alpha(c) || digit(c);
    endfunction
    function automatic bit op_lead(logic [7:0] c);
        return pair_code(c, "=") >= 0 || c == "&" || c == "|" || c == ":";
    endfunction

    function automatic void grow();
        if (run_len < 16'hFFFF) run_len++;
    endfunction

    function automatic void start_token();
        tok_line = line_now; tok_col = col_now; run_len = 1; flags = 0; acc = 0; wlen = 0;
    endfunction

    function automatic void word_put(logic [7:0] c);
        if (wlen < 8) wbuf[wlen] = c;
        if (wlen <= 8) wlen++;
    endfunction

    function automatic bit word_matches(string s);
        if (wlen > 8 || s.len() != wlen) return 0;
        for (int i = 0; i < wlen; i++)
            if (s[i] != wbuf[i]) return 0;
        return 1;
    endfunction

    function automatic void emit_word();
        for (int i = 0; i < 31; i++)
            if (word_matches(kw_names[i])) begin
                emit_tok(TK_KEYWORD, i, 0);
                return;
            end
        emit_tok(TK_IDENT, CODE_NONE, 0);
    endfunction

    function automatic void emit_directive();
        for (int i = 0; i < 13; i++)
            if (word_matches(dir_names[i])) begin
                emit_tok(TK_DIRECTIVE, i == 12 ? DIR_WARNING : i, 0);
                return;
            end
    endfunction

    function automatic void add_digit(logic [63:0] base, logic [63:0] d);
        if (flags & F_OVF) return;
        if (acc > (ACC_MAX - d) / base) begin
            acc = ACC_MAX;
            flags |= F_OVF;
        end else acc = acc * base + d;
    endfunction

    function automatic void restart_dot();
        tok_line = line_now; tok_col = col_now > 0 ? col_now - 1 : 0;
        run_len = 1; flags = 0; acc = 0;
    endfunction

    function automatic void idle_char(logic [7:0] c);
        if (c == CH_SPACE || c == CH_TAB) begin
            phase = LX_WS;
            return;
        end
        start_token();
        if (c == "/") begin phase = LX_SLASH; return; end
        if (c == CH_LF) begin emit_tok(TK_NEWLINE, CODE_NONE, 0); nl_mode = 1; return; end
        if (c == "(" || c == "[" || c == "{") begin
            if (depth < 16'hFFFF) depth++;
        end else if (c == ")" || c == "]" || c == "}") begin
            if (depth > 0) depth--;
        end
        if (c == CH_DQ || c == CH_SQ) begin
            flags = (c == CH_SQ) ? F_SQ : 0;
            phase = LX_STR;
            return;
        end
        if (digit(c)) begin
            acc = c - "0";
            phase = (c == "0") ? LX_ZERO : LX_INT;
            return;
        end
        if (c == ".") begin phase = LX_DOT; return; end
        if (c == "#") begin phase = LX_DIR_WS; return; end
        if (alpha(c)) begin word_put(c); phase = LX_IDENT; return; end
        if (op_lead(c)) begin held = c; phase = LX_OP; return; end
        emit_single(c);
    endfunction

    function automatic bit close_number();
        emit_tok(TK_NUMBER, CODE_NONE, 1);
        phase = LX_IDLE;
        return 1;
    endfunction

    function automatic bit int_char(logic [7:0] c);
        phase = LX_INT;
        if (digit(c)) begin add_digit(10, c - "0"); grow(); return 0; end
        if (c == ".") begin phase = LX_NDOT; return 0; end
        if (c == "e" || c == "E") begin
            flags |= F_FLOAT; grow(); phase = LX_EXP;
            return 0;
        end
        return close_number();
    endfunction

    // returns 1 when the character has to be taken again in the new phase
    function automatic bit lex_char(logic [7:0] c);
        int k;
        logic [7:0] q;
        case (phase)
            LX_WS: begin
                if (c == CH_SPACE || c == CH_TAB || c == CH_CR) return 0;
                phase = LX_IDLE; return 1;
            end
            LX_POSTBLK: begin
                if (c == CH_SPACE || c == CH_TAB) return 0;
                phase = LX_IDLE; return 1;
            end
            LX_SLASH: begin
                if (c == "/") begin phase = LX_LINE; return 0; end
                if (c == "*") begin phase = LX_BLK; return 0; end
                if (c == "=") begin
                    grow(); emit_tok(TK_OPER, OP_DIV_EQ, 0); phase = LX_IDLE;
                    return 0;
                end
                emit_tok(TK_OPER, OP_DIV, 0); phase = LX_IDLE; return 1;
            end
            LX_LINE: begin
                if (c == CH_LF) begin nl_mode = 1; phase = LX_IDLE; end
                return 0;
            end
            LX_BLK: begin
                if (c == "*") phase = LX_BSTAR;
                else if (c == CH_LF) nl_mode = 2;
                return 0;
            end
            LX_BSTAR: begin
                if (c == "/") phase = LX_POSTBLK;
                else if (c != "*") begin
                    if (c == CH_LF) nl_mode = 2;
                    phase = LX_BLK;
                end
                return 0;
            end
            LX_OP: begin
                k = pair_code(held, c);
                phase = LX_IDLE;
                if (k >= 0) begin grow(); emit_tok(TK_OPER, k, 0); return 0; end
                emit_single(held); return 1;
            end
            LX_DOT: begin
                if (digit(c)) begin grow(); flags |= F_FLOAT; phase = LX_FRAC; return 0; end
                if (c == ".") begin grow(); phase = LX_DOTDOT; return 0; end
                emit_tok(TK_OPER, OP_DOT, 0); phase = LX_IDLE; return 1;
            end
            LX_DOTDOT: begin
                phase = LX_IDLE;
                if (c == ".") begin grow(); emit_tok(TK_OPER, OP_ELLIPSIS, 0); return 0; end
                emit_tok(TK_OPER, OP_RANGE, 0); return 1;
            end
            LX_IDENT: begin
                if (word_char(c)) begin word_put(c); grow(); return 0; end
                emit_word(); phase = LX_IDLE; return 1;
            end
            LX_ZERO: begin
                if (c == "x" || c == "X") begin grow(); phase = LX_HEX; return 0; end
                return int_char(c);
            end
            LX_INT: return int_char(c);
            LX_NDOT: begin
                if (digit(c)) begin
                    grow(); grow(); flags |= F_FLOAT; phase = LX_FRAC;
                    return 0;
                end
                emit_tok(TK_NUMBER, CODE_NONE, 1);
                restart_dot();
                phase = LX_DOT; return 1;
            end
            LX_FRAC: begin
                if (digit(c)) begin grow(); return 0; end
                if (c == "e" || c == "E") begin grow(); phase = LX_EXP; return 0; end
                return close_number();
            end
            LX_EXP: begin
                if (c == "+" || c == "-" || digit(c)) begin grow(); phase = LX_EXPD; return 0; end
                return close_number();
            end
            LX_EXPD: begin
                if (digit(c)) begin grow(); return 0; end
                return close_number();
            end
            LX_HEX: begin
                if (digit(c)) k = c - "0";
                else if (c >= "a" && c <= "f") k = c - "a" + 10;
                else if (c >= "A" && c <= "F") k = c - "A" + 10;
                else k = -1;
                if (k >= 0) begin add_digit(16, k); grow(); return 0; end
                return close_number();
            end
            LX_STR: begin
                grow();
                q = (flags & F_SQ) ? CH_SQ : CH_DQ;
                if (c == q) begin emit_tok(TK_STRING, CODE_NONE, 0); phase = LX_IDLE; end
                else if (c == CH_BSL) phase = LX_ESC;
                return 0;
            end
            LX_ESC: begin grow(); phase = LX_STR; return 0; end
            LX_DIR_WS, LX_DIR_NAME: begin
                if (phase == LX_DIR_WS && (c == CH_SPACE || c == CH_TAB)) begin
                    grow(); return 0;
                end
                if (word_char(c)) begin
                    word_put((c >= "A" && c <= "Z") ? c + 8'd32 : c);
                    grow(); phase = LX_DIR_NAME; return 0;
                end
                if (phase == LX_DIR_NAME) emit_directive();
                phase = LX_IDLE; return 1;
            end
            default: begin
                phase = LX_IDLE;
                idle_char(c);
                return 0;
            end
        endcase
    endfunction

    function automatic void flush_lexer();
        case (phase)
            LX_SLASH:   emit_tok(TK_OPER, OP_DIV, 0);
            LX_OP:      emit_single(held);
            LX_DOT:     emit_tok(TK_OPER, OP_DOT, 0);
            LX_DOTDOT:  emit_tok(TK_OPER, OP_RANGE, 0);
            LX_IDENT:   emit_word();
            LX_ZERO, LX_INT, LX_FRAC, LX_EXP, LX_EXPD, LX_HEX:
                emit_tok(TK_NUMBER, CODE_NONE, 1);
            LX_NDOT: begin
                emit_tok(TK_NUMBER, CODE_NONE, 1);
                restart_dot();
                emit_tok(TK_OPER, OP_DOT, 0);
            end
            LX_STR, LX_ESC: emit_tok(TK_STRING, CODE_NONE, 0);
            LX_DIR_NAME: emit_directive();
            default: ;
        endcase
    endfunction

    function automatic void predict_tokens(logic [7:0] c, bit eos);
        step_tokens.delete();
        if (eos) begin
            flush_lexer();
            tok_line = line_now; tok_col = col_now; run_len = 0; flags = 0;
            emit_tok(TK_END, CODE_NONE, 0);
            reset_lexer();
        end else begin
            nl_mode = 0;
            while (lex_char(c)) ;
            if (nl_mode != 0) begin
                line_now = line_now < 16'hFFFF ? line_now + 1 : 16'hFFFF;
                col_now = (nl_mode == 2) ? 1 : 0;
            end else if (col_now < 16'hFFFF) col_now++;
        end
        if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
    endfunction

    // one transaction on the slave side, with bursts and gaps around it
    task automatic send_byte(logic [7:0] c, bit eos);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= c;
        i_s_axis_tuser <= eos;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_tokens(c, eos);
        items_sent++;
        burst_left--;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    endtask

    task automatic send_end();
        send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(t_cfg_idx idx, logic [15:0] val);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_FIRST_LINE) cfg_line = 32'(val); else cfg_col = 32'(val);
    endtask

    // receiver: randomly rerolled stall pattern, plus one long hold
    int rx_mode = 0, rx_cycle = 0, hold_left = 0;
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 64 == 0) rx_mode <= $urandom_range(0, 2);
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (hold_req) begin
            hold_req <= 1'b0;
            hold_left <= HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= (rx_mode == 0) ? 1'b1 :
                               ($urandom_range(0, 9) >= (rx_mode == 1 ? 3 : 7));
        end
    end

    // record checker
    always @(posedge i_clk) begin
        t_tok e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_tokens.size() == 0) begin
                $error("unexpected token record kind=%0d", o_m_axis_tuser);
                errors++;
            end else begin
                e = expected_tokens.pop_front();
                if (o_m_axis_tuser !== e.kind) begin
                    $error("token_kind exp %0d got %0d", e.kind, o_m_axis_tuser); errors++;
                end
                if (o_m_axis_tdata[5:0] !== e.code) begin
                    $error("token_code exp %0d got %0d", e.code, o_m_axis_tdata[5:0]); errors++;
                end
                if (o_m_axis_tdata[21:6] !== e.sline) begin
                    $error("start_line exp %0d got %0d", e.sline, o_m_axis_tdata[21:6]); errors++;
                end
                if (o_m_axis_tdata[37:22] !== e.scol) begin
                    $error("start_column exp %0d got %0d", e.scol, o_m_axis_tdata[37:22]);
                    errors++;
                end
                if (o_m_axis_tdata[53:38] !== e.len) begin
                    $error("token_length exp %0d got %0d", e.len, o_m_axis_tdata[53:38]);
                    errors++;
                end
                if (o_m_axis_tdata[116:54] !== e.ival) begin
                    $error("int_value exp %0d got %0d", e.ival, o_m_axis_tdata[116:54]);
                    errors++;
                end
                if (o_m_axis_tdata[117] !== e.isf) begin
                    $error("is_float exp %0d got %0d", e.isf, o_m_axis_tdata[117]); errors++;
                end
                if (o_m_axis_tdata[118] !== e.ovf) begin
                    $error("value_overflow exp %0d got %0d", e.ovf, o_m_axis_tdata[118]);
                    errors++;
                end
                if (o_m_axis_tdata[134:119] !== e.depth) begin
                    $error("bracket_depth exp %0d got %0d", e.depth, o_m_axis_tdata[134:119]);
                    errors++;
                end
                if (o_m_axis_tlast !== e.last) begin
                    $error("last_of_run exp %0d got %0d", e.last, o_m_axis_tlast); errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("** script_source_tokenizer_core: FAILED **");
            $finish;
        end
    end

    function automatic string random_fragment();
        string s;
        int n;
        case ($urandom_range(0, 13))
            0: return kw_names[$urandom_range(0, 30)];
            1: begin
                s = "";
                n = $urandom_range(1, 11);
                for (int i = 0; i < n; i++)
                    s = {s, string'(byte'(NAME_CHARS[$urandom_range(0, 4)]))};
                return {"w", s};
            end
            2: return $sformatf("%0d", $urandom_range(0, 99999));
            3: return $sformatf("0x%0h", $urandom);
            4: return $sformatf("%0d.%0de%s%0d", $urandom_range(0, 9), $urandom_range(0, 99),
                                $urandom_range(0, 1) ? "-" : "", $urandom_range(0, 9));
            5: return $urandom_range(0, 1) ? "\"a\\\"b\"" : "'x\\'\n'";
            6: return op_words[$urandom_range(0, 16)];
            7: return string'(byte'(OP_CHARS[$urandom_range(0, OP_CHARS.len() - 1)]));
            8: return $urandom_range(0, 1) ? "// c\n" : "/* a\n**/ ";
            9: return {"# ", dir_names[$urandom_range(0, 12)], " "};
            10: return $urandom_range(0, 1) ? " \t\r " : "\n";
            11: return "\r";
            12: return "5.";
            default: return " ";
        endcase
    endfunction

    task automatic test_reset();
        reset_lexer();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
    endtask

    task automatic test_directed_tokens();
        send_text("while x1 ({[ 0x1F ]})..1.5e+3");
        send_end();
        send_text("a/=b...c::#WARN #zz /\n// k\n");
        send_text("9223372036854775808 'q\\'");
        send_end();
    endtask

    task automatic test_config_extremes();
        write_cfg(CFG_FIRST_LINE, 16'hFFFF);
        write_cfg(CFG_FIRST_COL, 16'hFFFE);
        send_end();
        send_text("7.x\n12.");
        send_end();
        write_cfg(CFG_FIRST_LINE, 16'h0000);
        write_cfg(CFG_FIRST_COL, 16'h0000);
        send_end();
        send_text("/*\n*/ 0.");
        send_end();
        write_cfg(CFG_FIRST_LINE, 16'($urandom));
        write_cfg(CFG_FIRST_COL, 16'($urandom));
        send_end();
    endtask

    task automatic test_backpressure();
        wait_idle();
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++) send_text("a.");
        send_end();
    endtask

    task automatic test_random_source();
        string s;
        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 19))
                0: send_byte(8'($urandom_range(0, 255)), 1'b0);
                1: send_end();
                default: begin
                    s = random_fragment();
                    send_text(s);
                    if ($urandom_range(0, 2) == 0) send_byte(CH_SPACE, 1'b0);
                end
            endcase
        end
        send_end();
    endtask

    initial begin
        test_reset();
        test_directed_tokens();
        test_config_extremes();
        test_backpressure();
        test_random_source();
        wait_idle();
        if (errors == 0)
            $display("** script_source_tokenizer_core: PASSED **");
        else
            $display("** script_source_tokenizer_core: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/sst_pkg.sv
design/sst_lexer.sv
design/sst_outq.sv
design/script_source_tokenizer_core.sv
tb/tb_script_source_tokenizer_core.sv
